// ===== rtl/vslpf_pkg.sv =====
// Shared constants, register indexes and the configuration struct of the low-pass filter.
package vslpf_pkg;

    localparam int SAMPLE_WIDTH_DEF    = 32;
    localparam int COUNTER_WIDTH_DEF   = 24;
    localparam int ALPHA_FRAC_BITS_DEF = 24;

    localparam int TC_WIDTH        = 28;
    localparam int GAP_CFG_WIDTH   = 24;
    localparam int CFG_DATA_WIDTH  = 28;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIME_CONSTANT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_GAP       = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEFAULT_GAP   = 2'd2;

    localparam logic [TC_WIDTH-1:0]      TC_RESET          = 28'd34000000;
    localparam logic [GAP_CFG_WIDTH-1:0] MAX_GAP_RESET     = 24'd850000;
    localparam logic [GAP_CFG_WIDTH-1:0] DEFAULT_GAP_RESET = 24'd255000;

    typedef struct packed {
        logic [TC_WIDTH-1:0]      time_constant;
        logic [GAP_CFG_WIDTH-1:0] max_gap;
        logic [GAP_CFG_WIDTH-1:0] default_gap;
    } vslpf_cfg_t;

endpackage

// ===== rtl/variable_step_lowpass_filter_unit.sv =====
// A beat is accepted only in idle, then passes the prep, divide, multiply and finish states; a bypass
// beat goes straight from idle to finish. No new beat is taken until the current result is in the
// output register. The serial divider and the serial multiplier run one after the other.
// Results wait in an output register.
// Reset (rst_n, asynchronous, active low) loads the register defaults and clears the
// stored output and timestamp.
module variable_step_lowpass_filter_unit
    import vslpf_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int COUNTER_WIDTH   = COUNTER_WIDTH_DEF,
    parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [SAMPLE_WIDTH-1:0]    sample_in,
    input  logic [COUNTER_WIDTH-1:0]   tick_now,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [SAMPLE_WIDTH-1:0]    filtered_out,
    output logic                       was_reset,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int GAP_WIDTH = (COUNTER_WIDTH > GAP_CFG_WIDTH) ? COUNTER_WIDTH : GAP_CFG_WIDTH;
    localparam int DEN_WIDTH = ((GAP_WIDTH > TC_WIDTH) ? GAP_WIDTH : TC_WIDTH) + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    vslpf_cfg_t cfg;

    logic [2:0]               state_reg, state_next;
    logic [SAMPLE_WIDTH-1:0]  last_output_reg, last_output_next;
    logic [COUNTER_WIDTH-1:0] last_tick_reg, last_tick_next;
    logic [SAMPLE_WIDTH-1:0]  x_reg, x_next;
    logic [SAMPLE_WIDTH-1:0]  y_reg, y_next;
    logic [GAP_WIDTH-1:0]     gap_reg, gap_next;
    logic                     flag_reg, flag_next;
    logic                     out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0]  out_data_reg, out_data_next;
    logic                     out_flag_reg, out_flag_next;

    logic [COUNTER_WIDTH-1:0] tick_diff;
    logic [COUNTER_WIDTH-1:0] gap_raw;
    logic [GAP_WIDTH-1:0]     gap_eff;
    logic                     bypass;
    logic                     accept;
    logic                     out_free;

    logic [DEN_WIDTH-1:0]       den;
    logic                       div_start, div_done;
    logic [ALPHA_FRAC_BITS:0]   alpha;
    logic                       mul_start, mul_done;
    logic [SAMPLE_WIDTH:0]      diff;
    logic [SAMPLE_WIDTH+2:0]    prod;
    logic [SAMPLE_WIDTH+2:0]    y_sum;

    vslpf_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vslpf_div #(
        .DEN_WIDTH       (DEN_WIDTH),
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .tc    (cfg.time_constant),
        .den   (den),
        .done  (div_done),
        .alpha (alpha)
    );

    vslpf_mul #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .diff  (diff),
        .alpha (alpha),
        .done  (mul_done),
        .prod  (prod)
    );

    assign in_ready     = (state_reg == ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign filtered_out = out_data_reg;
    assign was_reset    = out_flag_reg;
    assign out_free     = !out_valid_reg || out_ready;

    // A timer that has not moved down has reloaded; one tick is spent on the reload.
    assign tick_diff = last_tick_reg - tick_now;
    assign gap_raw   = (tick_now < last_tick_reg) ? tick_diff : (tick_diff - 1'b1);
    assign gap_eff   = (gap_raw == '0) ? GAP_WIDTH'(cfg.default_gap) : GAP_WIDTH'(gap_raw);
    assign bypass    = (gap_raw != '0) && (GAP_WIDTH'(gap_raw) > GAP_WIDTH'(cfg.max_gap));

    assign den       = DEN_WIDTH'(cfg.time_constant) + DEN_WIDTH'(gap_reg);
    assign div_start = (state_reg == ST_PREP);
    assign mul_start = (state_reg == ST_DIV) && div_done;
    assign diff      = {last_output_reg[SAMPLE_WIDTH-1], last_output_reg}
                     - {x_reg[SAMPLE_WIDTH-1], x_reg};
    assign y_sum     = {{3{x_reg[SAMPLE_WIDTH-1]}}, x_reg} + prod;

    always_comb
    begin
        state_next       = state_reg;
        last_output_next = last_output_reg;
        last_tick_next   = last_tick_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        gap_next         = gap_reg;
        flag_next        = flag_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        out_flag_next    = out_flag_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next         = sample_in;
                    last_tick_next = tick_now;
                    gap_next       = gap_eff;
                    flag_next      = bypass;
                    if (bypass)
                    begin
                        y_next     = sample_in;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    y_next     = y_sum[SAMPLE_WIDTH-1:0];
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_data_next    = y_reg;
                    out_flag_next    = flag_reg;
                    last_output_next = y_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            last_output_reg <= '0;
            last_tick_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            last_output_reg <= last_output_next;
            last_tick_reg   <= last_tick_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        gap_reg      <= gap_next;
        flag_reg     <= flag_next;
        out_data_reg <= out_data_next;
        out_flag_reg <= out_flag_next;
    end

endmodule

// ===== rtl/vslpf_cfg.sv =====
// Configuration register file of the low-pass filter.
module vslpf_cfg
    import vslpf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output vslpf_cfg_t                 cfg
);

    vslpf_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_constant <= TC_RESET;
            cfg_reg.max_gap       <= MAX_GAP_RESET;
            cfg_reg.default_gap   <= DEFAULT_GAP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TIME_CONSTANT: cfg_reg.time_constant <= cfg_data[TC_WIDTH-1:0];
                REG_MAX_GAP:       cfg_reg.max_gap       <= cfg_data[GAP_CFG_WIDTH-1:0];
                REG_DEFAULT_GAP:   cfg_reg.default_gap   <= cfg_data[GAP_CFG_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/vslpf_div.sv =====
// Restoring divider that produces the filter coefficient one quotient bit per cycle.
module vslpf_div
    import vslpf_pkg::*;
#(
    parameter int DEN_WIDTH       = TC_WIDTH + 1,
    parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [TC_WIDTH-1:0]      tc,
    input  logic [DEN_WIDTH-1:0]     den,
    output logic                     done,
    output logic [ALPHA_FRAC_BITS:0] alpha
);

    localparam int CNT_WIDTH = $clog2(ALPHA_FRAC_BITS + 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_WIDTH-1:0]     cnt_reg, cnt_next;
    logic [DEN_WIDTH:0]       rem_reg, rem_next;
    logic [DEN_WIDTH-1:0]     den_reg, den_next;
    logic [ALPHA_FRAC_BITS:0] q_reg, q_next;
    logic                     ge;
    logic [DEN_WIDTH:0]       rem_sub;

    assign done  = done_reg;
    assign alpha = q_reg;

    // Remainder stays below the divisor after each subtract, so the doubled value fits.
    assign ge      = rem_reg >= {1'b0, den_reg};
    assign rem_sub = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (start)
        begin
            rem_next = (DEN_WIDTH + 1)'(tc);
            den_next = den;
            q_next   = '0;
            cnt_next = '0;
            if (den == '0)
            begin
                // A zero denominator gives a zero coefficient.
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = {rem_sub[DEN_WIDTH-1:0], 1'b0};
            q_next   = {q_reg[ALPHA_FRAC_BITS-1:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_WIDTH'(ALPHA_FRAC_BITS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

endmodule

// ===== rtl/vslpf_mul.sv =====
// Serial shift-and-add multiplier that forms floor(diff * alpha / 2^frac) one alpha bit per cycle.
module vslpf_mul
    import vslpf_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [SAMPLE_WIDTH:0]     diff,
    input  logic [ALPHA_FRAC_BITS:0]  alpha,
    output logic                      done,
    output logic [SAMPLE_WIDTH+2:0]   prod
);

    localparam int ACC_WIDTH = SAMPLE_WIDTH + 3;
    localparam int CNT_WIDTH = $clog2(ALPHA_FRAC_BITS + 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_WIDTH-1:0]     cnt_reg, cnt_next;
    logic [ACC_WIDTH-1:0]     acc_reg, acc_next;
    logic [SAMPLE_WIDTH:0]    diff_reg, diff_next;
    logic [ALPHA_FRAC_BITS:0] a_reg, a_next;
    logic [ACC_WIDTH-1:0]     addend;
    logic [ACC_WIDTH-1:0]     sum;

    assign done = done_reg;
    assign prod = acc_reg;

    assign addend = a_reg[0] ? {{2{diff_reg[SAMPLE_WIDTH]}}, diff_reg} : '0;
    assign sum    = acc_reg + addend;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        diff_next = diff_reg;
        a_next    = a_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            diff_next = diff;
            a_next    = alpha;
        end
        else if (busy_reg)
        begin
            a_next   = a_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_WIDTH'(ALPHA_FRAC_BITS))
            begin
                // The integer bit of alpha is added without a shift.
                acc_next  = sum;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                // Each fraction bit drops one bit with a flooring shift.
                acc_next = {sum[ACC_WIDTH-1], sum[ACC_WIDTH-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        diff_reg <= diff_next;
        a_reg    <= a_next;
    end

endmodule
